>>> design/sgcc_pkg.sv
// Shared types and constants for the sphere grid cell connectivity block.
// No dependencies.
`timescale 1ns / 1ps
package sgcc_pkg;

  localparam int CELL_W   = 14;
  localparam int VERT_W   = 14;
  localparam int OFF_W    = 16;
  localparam int ORDER_W  = 6;
  localparam int RING_W   = 8;
  localparam int QUOT_W   = 6;

  localparam logic REG_ORDER = 1'b0;

  typedef struct packed {
    logic [CELL_W-1:0]  cnum;
    logic [CELL_W-1:0]  rem;
    logic [RING_W-1:0]  ring;
    logic [CELL_W-1:0]  base;
  } sgcc_item_t;

endpackage

>>> design/sgcc_mod_stage.sv
// One pipeline stage of the remainder-by-ring-size unit: conditional subtract
// of the shifted ring size. Depends on sgcc_pkg.
`timescale 1ns / 1ps
module sgcc_mod_stage #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  sgcc_pkg::sgcc_item_t up_item,
  output logic                dn_valid,
  input  logic                dn_ready,
  output sgcc_pkg::sgcc_item_t dn_item
);

  localparam int CW = sgcc_pkg::CELL_W;
  localparam int TW = CW + 1;

  logic                 valid_r;
  sgcc_pkg::sgcc_item_t item_r;
  sgcc_pkg::sgcc_item_t item_nxt;
  logic [TW-1:0]        trial;

  assign up_ready = !valid_r || dn_ready;
  assign trial    = TW'(up_item.ring) << SHIFT;

  always_comb begin
    item_nxt = up_item;
    if (TW'(up_item.rem) >= trial) begin
      item_nxt.rem = CW'(TW'(up_item.rem) - trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

>>> design/sphere_grid_cell_connectivity.sv
// Pipeline: 8 register stages (setup, six remainder stages, output). Throughput:
// one item per cycle while out_stall is low; each stage holds its item under
// stall and fills bubbles ahead of it. Reset: synchronous active-low rst_n
// clears all valid bits and sets the order register to 0. Depends on sgcc_pkg
// and sgcc_mod_stage.
`timescale 1ns / 1ps
module sphere_grid_cell_connectivity #(
  parameter int MAX_ORDER = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_cell_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_vertex_first,
  output logic [13:0] out_vertex_second,
  output logic [13:0] out_vertex_third,
  output logic [13:0] out_vertex_fourth,
  output logic        out_is_quad,
  output logic [15:0] out_end_offset,
  output logic        out_out_of_range
);

  localparam int CW  = sgcc_pkg::CELL_W;
  localparam int OW  = sgcc_pkg::ORDER_W;
  localparam int RW  = sgcc_pkg::RING_W;
  localparam int NQ  = sgcc_pkg::QUOT_W;
  localparam int SAT = (MAX_ORDER < 63) ? MAX_ORDER : 63;
  localparam int EW  = sgcc_pkg::OFF_W + 1;

  // configuration
  logic [OW-1:0] order_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == sgcc_pkg::REG_ORDER)) begin
      order_r <= pwdata[OW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == sgcc_pkg::REG_ORDER) begin
      prdata = 32'(order_r);
    end
  end

  // setup stage
  logic [OW-1:0]        p_eff;
  logic [RW-1:0]        ring;
  sgcc_pkg::sgcc_item_t s0_nxt;
  sgcc_pkg::sgcc_item_t s0_r;
  logic                 s0_valid_r;
  logic                 s0_ready;

  logic                 vld [NQ+1];
  logic                 rdy [NQ+1];
  sgcc_pkg::sgcc_item_t itm [NQ+1];

  assign p_eff = (order_r > OW'(SAT)) ? OW'(SAT) : order_r;
  assign ring  = RW'({p_eff, 1'b0}) + RW'(2);

  always_comb begin
    s0_nxt.cnum = in_cell_number;
    s0_nxt.rem  = in_cell_number;
    s0_nxt.ring = ring;
    s0_nxt.base = CW'(ring) * (CW'(p_eff) + CW'(1));
  end

  assign s0_ready = !s0_valid_r || rdy[0];
  assign in_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0_r <= s0_nxt;
    end
  end

  assign vld[0] = s0_valid_r;
  assign itm[0] = s0_r;

  // remainder pipeline, quotient bits high to low
  for (genvar g = 0; g < NQ; g++) begin : g_mod
    sgcc_mod_stage #(
      .SHIFT(NQ - 1 - g)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(vld[g]),
      .up_ready(rdy[g]),
      .up_item (itm[g]),
      .dn_valid(vld[g+1]),
      .dn_ready(rdy[g+1]),
      .dn_item (itm[g+1])
    );
  end

  // output stage
  sgcc_pkg::sgcc_item_t fin;
  logic                 out_valid_r;
  logic                 out_ready;
  logic [CW:0]          c1, r1, b1;
  logic [CW-1:0]        v0_nxt, v1_nxt, v2_nxt, v3_nxt;
  logic                 quad_nxt, oor_nxt;
  logic [EW-1:0]        off_nxt;
  logic [CW-1:0]        v0_r, v1_r, v2_r, v3_r;
  logic                 quad_r, oor_r;
  logic [sgcc_pkg::OFF_W-1:0] off_r;

  assign fin       = itm[NQ];
  assign out_ready = !out_valid_r || !out_stall;
  assign rdy[NQ]   = out_ready;
  assign c1        = (CW+1)'(fin.cnum);
  assign r1        = (CW+1)'(fin.ring);
  assign b1        = (CW+1)'(fin.base);

  always_comb begin
    v0_nxt   = '0;
    v1_nxt   = '0;
    v2_nxt   = '0;
    v3_nxt   = '0;
    quad_nxt = 1'b0;
    oor_nxt  = 1'b0;
    off_nxt  = '0;
    if (c1 >= b1 + r1) begin
      oor_nxt = 1'b1;
    end else if (c1 < r1) begin
      // north cap
      if (c1 < r1 - 1'b1) begin
        v1_nxt = CW'(c1 + 1'b1);
        v2_nxt = CW'(c1 + 2'd2);
      end else begin
        v1_nxt = CW'(r1);
        v2_nxt = CW'(1);
      end
      off_nxt = EW'(3 * (EW'(c1) + 1'b1));
    end else if (c1 < b1) begin
      // band quads; wrap on the last cell of a ring
      quad_nxt = 1'b1;
      v0_nxt   = CW'(c1 + 1'b1);
      v3_nxt   = CW'(c1 + 1'b1 - r1);
      if (fin.rem == CW'(r1 - 1'b1)) begin
        v1_nxt = CW'(c1 + 2'd2 - r1);
        v2_nxt = CW'(c1 + 2'd2 - r1 - r1);
      end else begin
        v1_nxt = CW'(c1 + 2'd2);
        v2_nxt = CW'(c1 + 2'd2 - r1);
      end
      off_nxt = EW'({EW'(c1), 2'b00}) + EW'(4) - EW'(r1);
    end else begin
      // south cap, wrap triangle first
      v0_nxt = CW'(b1 + 1'b1);
      if (c1 == b1) begin
        v1_nxt = CW'(b1);
        v2_nxt = CW'(b1 + 1'b1 - r1);
      end else begin
        v1_nxt = CW'(b1 + b1 + 1'b1 - c1);
        v2_nxt = CW'(b1 + b1 - c1);
      end
      off_nxt = EW'(b1) - EW'(r1) + EW'(3 * EW'(c1)) + EW'(3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= vld[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && vld[NQ]) begin
      v0_r   <= v0_nxt;
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
      v3_r   <= v3_nxt;
      quad_r <= quad_nxt;
      oor_r  <= oor_nxt;
      off_r  <= off_nxt[sgcc_pkg::OFF_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vertex_first  = v0_r;
  assign out_vertex_second = v1_r;
  assign out_vertex_third  = v2_r;
  assign out_vertex_fourth = v3_r;
  assign out_is_quad       = quad_r;
  assign out_end_offset    = off_r;
  assign out_out_of_range  = oor_r;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for sphere_grid_cell_connectivity: random and boundary cell
// numbers over several mesh orders, each result checked field by field against a local model.
// Depends on sgcc_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;

  localparam int CELL_W = sgcc_pkg::CELL_W;
  localparam int VERT_W = sgcc_pkg::VERT_W;
  localparam int OFF_W = sgcc_pkg::OFF_W;
  localparam int ORDER_W = sgcc_pkg::ORDER_W;
  localparam int MAX_ORD = 63;
  localparam int N_PHASES = 8;
  localparam int RANDOM_PER_PHASE = 105;
  localparam int LONG_HOLD = 80;
  localparam int CELL_MAX = (1 << CELL_W) - 1;
  localparam logic [2:0] ORDER_ADDR = 3'(4 * sgcc_pkg::REG_ORDER);

  typedef struct {
    int                cnum;
    logic [VERT_W-1:0] v1;
    logic [VERT_W-1:0] v2;
    logic [VERT_W-1:0] v3;
    logic [VERT_W-1:0] v4;
    logic              quad;
    logic [OFF_W-1:0]  off;
    logic              oor;
  } cell_conn_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CELL_W-1:0] in_cell_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VERT_W-1:0] out_vertex_first;
  logic [VERT_W-1:0] out_vertex_second;
  logic [VERT_W-1:0] out_vertex_third;
  logic [VERT_W-1:0] out_vertex_fourth;
  logic out_is_quad;
  logic [OFF_W-1:0] out_end_offset;
  logic out_out_of_range;

  int cells_to_send[$];
  cell_conn_t due_cells[$];
  logic [ORDER_W-1:0] cur_order = '0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic idle_on = 1'b1;
  int send_gap = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_oor = 0;
  int n_quad = 0;
  int n_errors = 0;

  sphere_grid_cell_connectivity #(.MAX_ORDER(MAX_ORD)) u_top (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_number(in_cell_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vertex_first(out_vertex_first), .out_vertex_second(out_vertex_second),
    .out_vertex_third(out_vertex_third), .out_vertex_fourth(out_vertex_fourth),
    .out_is_quad(out_is_quad), .out_end_offset(out_end_offset),
    .out_out_of_range(out_out_of_range)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // vertex indices, kind and running offset of one cell for mesh order ord
  function automatic cell_conn_t mesh_cell(input int cnum, input int ord);
    cell_conn_t res;
    int p, r, s, base, j, k, idx;
    p = (ord > MAX_ORD) ? MAX_ORD : ord;
    r = 2 * p + 2;
    s = r * (p + 1) + 1;
    base = r * (p + 1);
    res = '{cnum: cnum, v1: '0, v2: '0, v3: '0, v4: '0, quad: 1'b0, off: '0, oor: 1'b0};
    if (cnum >= r * (p + 2)) begin
      res.oor = 1'b1;
    end else if (cnum < r) begin
      res.v2 = VERT_W'((cnum < r - 1) ? cnum + 1 : r);
      res.v3 = VERT_W'((cnum < r - 1) ? cnum + 2 : 1);
      res.off = OFF_W'(3 * (cnum + 1));
    end else if (cnum < base) begin
      j = cnum / r;
      k = cnum - j * r;
      res.quad = 1'b1;
      if (k < r - 1) begin
        idx = j * r + k + 1;
        res.v2 = VERT_W'(idx + 1);
        res.v3 = VERT_W'(idx + 1 - r);
      end else begin
        idx = (j + 1) * r;
        res.v2 = VERT_W'(idx - r + 1);
        res.v3 = VERT_W'(idx - r + 1 - r);
      end
      res.v1 = VERT_W'(idx);
      res.v4 = VERT_W'(idx - r);
      res.off = OFF_W'(3 * r + 4 * (cnum - r + 1));
    end else begin
      res.v1 = VERT_W'(s);
      if (cnum == base) begin
        res.v2 = VERT_W'(s - 1);
        res.v3 = VERT_W'(s - r);
      end else begin
        k = cnum - base - 1;
        res.v2 = VERT_W'(s - 1 - k);
        res.v3 = VERT_W'(s - 2 - k);
      end
      res.off = OFF_W'(3 * r + 4 * p * r + 3 * (cnum - base + 1));
    end
    return res;
  endfunction

  // region boundaries: cap ends, wrap cells, band limits, range limit
  function automatic int edge_cell(input int p, input int sel);
    int r;
    r = 2 * p + 2;
    case (sel)
      0: return 0;
      1: return r - 2;
      2: return r - 1;
      3: return r;
      4: return 2 * r - 1;
      5: return r * (p + 1) - 1;
      6: return r * (p + 1);
      7: return r * (p + 1) + 1;
      8: return r * (p + 2) - 1;
      9: return r * (p + 2);
      default: return CELL_MAX;
    endcase
  endfunction

  function automatic int random_cell(input int p);
    int total;
    total = (2 * p + 2) * (p + 2);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, CELL_MAX);
      1: return edge_cell(p, $urandom_range(0, 10));
      default: return $urandom_range(0, total - 1);
    endcase
  endfunction

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 9) : 0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < 40) $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input int cnum, input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("cell %0d %s got %0d want %0d", cnum, name, got, want));
  endtask

  task automatic queue_cell(input int cnum);
    cells_to_send.insert(cells_to_send.size(), cnum);
    n_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || due_cells.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ORDER_ADDR) cur_order = data[ORDER_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // sender: one gap draw per item, payload held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_cell_number <= '0;
      send_gap = 0;
    end else if (!in_valid || in_took) begin
      if (in_valid) send_gap = draw_wait();
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cells_to_send.size() > 0) begin
        in_valid <= 1'b1;
        in_cell_number <= CELL_W'(cells_to_send.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: per-item stall draw, plus long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = LONG_HOLD;
      end
      if (out_took) recv_wait = draw_wait();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    cell_conn_t want;
    in_took <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      due_cells.insert(due_cells.size(), mesh_cell(in_cell_number, cur_order));
      n_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_cells.size() == 0) begin
        report_mismatch("result with no cell outstanding");
      end else begin
        want = due_cells.pop_front();
        check_field(want.cnum, "vertex_first", out_vertex_first, want.v1);
        check_field(want.cnum, "vertex_second", out_vertex_second, want.v2);
        check_field(want.cnum, "vertex_third", out_vertex_third, want.v3);
        check_field(want.cnum, "vertex_fourth", out_vertex_fourth, want.v4);
        check_field(want.cnum, "is_quad", out_is_quad, want.quad);
        check_field(want.cnum, "end_offset", out_end_offset, want.off);
        check_field(want.cnum, "out_of_range", out_out_of_range, want.oor);
        n_results++;
        if (want.oor) n_oor++;
        if (want.quad) n_quad++;
      end
    end
  end

  initial begin : stimulus
    int ph, p, i, n;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: p = 0;
        1: p = MAX_ORD;
        2: p = 1;
        3: p = 2;
        4: p = 62;
        7: p = 31;
        default: p = $urandom_range(3, 60);
      endcase
      wait_drained();
      // upper data bits are don't-care for the order register
      write_reg(ORDER_ADDR, ($urandom() & ~32'h3F) | 32'(p));
      idle_on = (ph != 2 && ph != 5);
      if (ph == 2) hold_asked++;
      if (p == 0 || p == MAX_ORD)
        for (i = 0; i <= 10; i++) queue_cell(edge_cell(p, i));
      for (n = 0; n < RANDOM_PER_PHASE; n++) queue_cell(random_cell(p));
    end
    wait_drained();
    repeat (12) @(negedge clk);
    if (due_cells.size() != 0) report_mismatch("results still outstanding at end");
    $display("Checked %0d cells over %0d mesh orders: %0d quads, %0d out of range.",
             n_results, N_PHASES, n_quad, n_oor);
    if (n_errors == 0) begin
      $display("sphere_grid_cell_connectivity regression: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("sphere_grid_cell_connectivity regression: fail");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("timeout");
    $display("sphere_grid_cell_connectivity regression: fail");
    $finish;
  end

endmodule
